// ===== hw/rtl/wli_pkg.sv =====
// shared types, constants and codes of the wind layer interpolator
`timescale 1ns / 1ps
`default_nettype none

package wli_pkg;

   localparam int MAX_LAYERS_DEFAULT = 16;
   localparam int COUNT_W            = 5;
   localparam int DIV_STEPS          = 17;
   localparam int NUM_FIELDS         = 5;
   localparam int STEP_W             = 5;
   localparam logic [1:0] CSR_LAYER_COUNT_ADDR = 2'd0;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [3:0]         layer_index;
      logic signed [15:0] layer_altitude;
      logic [15:0]        layer_speed;
      logic [15:0]        layer_direction;
      logic signed [15:0] layer_vertical;
      logic [15:0]        layer_gust;
      logic [15:0]        layer_turbulence;
      logic signed [15:0] query_altitude;
   } req_type;

   typedef struct packed {
      logic [15:0]        wind_speed;
      logic [15:0]        wind_direction;
      logic signed [15:0] vertical_wind;
      logic [15:0]        gust_speed;
      logic [15:0]        turbulence_level;
      logic               no_layers;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] altitude;
      logic [15:0]        speed;
      logic [15:0]        direction;
      logic signed [15:0] vertical;
      logic [15:0]        gust;
      logic [15:0]        turbulence;
   } layer_type;

   localparam int LAYER_W = $bits(layer_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_EDGE_DATA,
      ST_RD_HI,
      ST_HI_DATA,
      ST_DIVIDE,
      ST_MUL,
      ST_MUL_TAIL
   } ctrl_state_type;

   typedef enum logic [2:0] {
      ADDR_SCAN,
      ADDR_MIN,
      ADDR_MAX,
      ADDR_LO,
      ADDR_HI
   } addr_sel_type;

   typedef enum logic [2:0] {
      FLD_SPEED,
      FLD_DIR,
      FLD_VERT,
      FLD_GUST,
      FLD_TURB
   } field_type;

   typedef struct packed {
      logic         wr_en;
      logic         load_query;
      logic         load_empty;
      logic         scan_rd;
      addr_sel_type addr_sel;
      logic         latch_lo;
      logic         latch_hi;
      logic         div_step;
      logic         div_first;
      logic         mul_go;
      field_type    mul_field;
      logic         load_edge;
      logic         emit;
   } cmd_type;

   typedef struct packed {
      logic q_le_min;
      logic q_ge_max;
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/wli_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module wli_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wli_ctrl.sv =====
// controller state machine sequencing scan, divide and blend
`timescale 1ns / 1ps
`default_nettype none

module wli_ctrl #(
   parameter int MAX_LAYERS = wli_pkg::MAX_LAYERS_DEFAULT,
   localparam int AW    = $clog2(MAX_LAYERS),
   localparam int CNT_W = $clog2(MAX_LAYERS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire wli_pkg::op_type      op,
   input  wire logic [CNT_W-1:0]     layer_total,
   input  wire wli_pkg::status_type  status,
   output logic                      busy,
   output wli_pkg::cmd_type          cmd,
   output logic [AW-1:0]             scan_addr
);

   wli_pkg::ctrl_state_type         state_ff, state_in;
   logic [AW-1:0]                   scan_idx_ff, scan_idx_in;
   logic [wli_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                            scan_last;

   assign scan_last = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == layer_total;
   assign scan_addr = scan_idx_ff;
   assign busy      = (state_ff != wli_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= wli_pkg::ST_IDLE;
         scan_idx_ff <= '0;
         step_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         step_ff     <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.addr_sel = wli_pkg::ADDR_SCAN;
      cmd.mul_field = wli_pkg::FLD_SPEED;
      unique case (state_ff)
         wli_pkg::ST_IDLE: begin
            if (start) begin
               if (op == wli_pkg::OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else if (layer_total == '0) begin
                  cmd.load_empty = 1'b1;
                  cmd.emit       = 1'b1;
               end else begin
                  cmd.load_query = 1'b1;
                  scan_idx_in    = '0;
                  state_in       = wli_pkg::ST_SCAN;
               end
            end
         end
         wli_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (scan_last) begin
               state_in = wli_pkg::ST_SCAN_END;
            end else begin
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end
         wli_pkg::ST_SCAN_END: begin
            // last altitude is folded into the trackers this cycle
            state_in = wli_pkg::ST_DECIDE;
         end
         wli_pkg::ST_DECIDE: begin
            if (status.q_le_min) begin
               cmd.addr_sel = wli_pkg::ADDR_MIN;
               state_in     = wli_pkg::ST_EDGE_DATA;
            end else if (status.q_ge_max) begin
               cmd.addr_sel = wli_pkg::ADDR_MAX;
               state_in     = wli_pkg::ST_EDGE_DATA;
            end else begin
               cmd.addr_sel = wli_pkg::ADDR_LO;
               state_in     = wli_pkg::ST_RD_HI;
            end
         end
         wli_pkg::ST_EDGE_DATA: begin
            cmd.load_edge = 1'b1;
            cmd.emit      = 1'b1;
            state_in      = wli_pkg::ST_IDLE;
         end
         wli_pkg::ST_RD_HI: begin
            cmd.addr_sel = wli_pkg::ADDR_HI;
            cmd.latch_lo = 1'b1;
            state_in     = wli_pkg::ST_HI_DATA;
         end
         wli_pkg::ST_HI_DATA: begin
            cmd.latch_hi = 1'b1;
            step_in      = '0;
            state_in     = wli_pkg::ST_DIVIDE;
         end
         wli_pkg::ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (step_ff == '0);
            if (step_ff == wli_pkg::STEP_W'(wli_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = wli_pkg::ST_MUL;
            end else begin
               step_in = step_ff + wli_pkg::STEP_W'(1);
            end
         end
         wli_pkg::ST_MUL: begin
            cmd.mul_go    = 1'b1;
            cmd.mul_field = wli_pkg::field_type'(step_ff[2:0]);
            if (step_ff == wli_pkg::STEP_W'(wli_pkg::NUM_FIELDS - 1)) begin
               state_in = wli_pkg::ST_MUL_TAIL;
            end else begin
               step_in = step_ff + wli_pkg::STEP_W'(1);
            end
         end
         wli_pkg::ST_MUL_TAIL: begin
            cmd.emit = 1'b1;
            state_in = wli_pkg::ST_IDLE;
         end
         default: begin
            state_in = wli_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wli_datapath.sv =====
// layer table, altitude scan trackers, serial divider and shared blend multiplier
`timescale 1ns / 1ps
`default_nettype none

module wli_datapath #(
   parameter int MAX_LAYERS = wli_pkg::MAX_LAYERS_DEFAULT,
   localparam int AW = $clog2(MAX_LAYERS)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire wli_pkg::cmd_type    cmd,
   input  wire logic [AW-1:0]       scan_addr,
   input  wire wli_pkg::req_type    req_payload,
   output wli_pkg::status_type      status,
   output logic                     rsp_strobe,
   output wli_pkg::rsp_type         rsp_payload
);

   wli_pkg::layer_type           wr_entry, rd_entry, lo_ff;
   logic [wli_pkg::LAYER_W-1:0]  rd_bits;
   logic                         wr_en;
   logic [AW-1:0]                rd_addr;

   logic                         scan_vld_ff, add_vld_ff, rsp_valid_ff;
   logic                         have_lo_ff, have_hi_ff;
   logic [AW-1:0]                scan_idx_ff, imin_ff, imax_ff, ilo_ff, ihi_ff;
   logic signed [15:0]           q_ff, min_alt_ff, max_alt_ff, lo_alt_ff, hi_alt_ff;
   logic signed [15:0]           alt;
   logic                         scan_first, below_q;

   logic [15:0]                  den_ff, rem_ff, rem_in;
   logic [16:0]                  quot_ff, trial;
   logic                         quot_bit;
   logic signed [17:0]           diff_ff [wli_pkg::NUM_FIELDS];
   logic signed [17:0]           dir_raw, dir_adj;
   logic signed [35:0]           prod_full;
   logic [15:0]                  prod_ff, lo_sel, sum;
   wli_pkg::field_type           add_field_ff;
   wli_pkg::rsp_type             rsp_ff;

   assign wr_en = cmd.wr_en && (32'(req_payload.layer_index) < 32'(MAX_LAYERS));

   always_comb begin
      wr_entry.altitude   = req_payload.layer_altitude;
      wr_entry.speed      = req_payload.layer_speed;
      wr_entry.direction  = req_payload.layer_direction;
      wr_entry.vertical   = req_payload.layer_vertical;
      wr_entry.gust       = req_payload.layer_gust;
      wr_entry.turbulence = req_payload.layer_turbulence;
   end

   always_comb begin
      case (cmd.addr_sel)
         wli_pkg::ADDR_MIN: rd_addr = imin_ff;
         wli_pkg::ADDR_MAX: rd_addr = imax_ff;
         wli_pkg::ADDR_LO:  rd_addr = ilo_ff;
         wli_pkg::ADDR_HI:  rd_addr = ihi_ff;
         default:           rd_addr = scan_addr;
      endcase
   end

   wli_ram #(
      .WIDTH (wli_pkg::LAYER_W),
      .DEPTH (MAX_LAYERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_payload.layer_index)),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry   = rd_bits;
   assign alt        = rd_entry.altitude;
   assign scan_first = (scan_idx_ff == '0);
   assign below_q    = (alt < q_ff);

   assign status.q_le_min = (q_ff <= min_alt_ff);
   assign status.q_ge_max = (q_ff >= max_alt_ff);

   // shortest arc: wrap into a half turn either way, an exact half turn keeps its sign
   always_comb begin
      dir_raw = 18'(rd_entry.direction) - 18'(lo_ff.direction);
      if (dir_raw > 18'sd32768) begin
         dir_adj = dir_raw - 18'sd65536;
      end else if (dir_raw < -18'sd32768) begin
         dir_adj = dir_raw + 18'sd65536;
      end else begin
         dir_adj = dir_raw;
      end
   end

   // restoring divide, one quotient bit a cycle, remainder stays below the span
   assign trial    = cmd.div_first ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign quot_bit = (trial >= {1'b0, den_ff});
   assign rem_in   = quot_bit ? 16'(trial - {1'b0, den_ff}) : trial[15:0];

   assign prod_full = $signed({1'b0, quot_ff}) * diff_ff[cmd.mul_field];

   always_comb begin
      case (add_field_ff)
         wli_pkg::FLD_SPEED: lo_sel = lo_ff.speed;
         wli_pkg::FLD_DIR:   lo_sel = lo_ff.direction;
         wli_pkg::FLD_VERT:  lo_sel = lo_ff.vertical;
         wli_pkg::FLD_GUST:  lo_sel = lo_ff.gust;
         default:            lo_sel = lo_ff.turbulence;
      endcase
   end

   // only the low 16 bits survive, so the sign of the low value does not matter
   assign sum = lo_sel + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_ff  <= 1'b0;
         add_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_lo_ff   <= 1'b0;
         have_hi_ff   <= 1'b0;
      end else begin
         scan_vld_ff  <= cmd.scan_rd;
         add_vld_ff   <= cmd.mul_go;
         rsp_valid_ff <= cmd.emit;
         if (cmd.load_query) begin
            have_lo_ff <= 1'b0;
            have_hi_ff <= 1'b0;
         end else if (scan_vld_ff) begin
            if (below_q) begin
               have_lo_ff <= 1'b1;
            end else begin
               have_hi_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_addr;
      add_field_ff <= cmd.mul_field;
      if (cmd.load_query) begin
         q_ff <= req_payload.query_altitude;
      end
      // strict compares keep the lowest index among equal altitudes
      if (scan_vld_ff) begin
         if (scan_first) begin
            min_alt_ff <= alt;
            imin_ff    <= scan_idx_ff;
            max_alt_ff <= alt;
            imax_ff    <= scan_idx_ff;
         end else begin
            if (alt < min_alt_ff) begin
               min_alt_ff <= alt;
               imin_ff    <= scan_idx_ff;
            end
            if (alt > max_alt_ff) begin
               max_alt_ff <= alt;
               imax_ff    <= scan_idx_ff;
            end
         end
         if (below_q) begin
            if (!have_lo_ff || alt > lo_alt_ff) begin
               lo_alt_ff <= alt;
               ilo_ff    <= scan_idx_ff;
            end
         end else if (!have_hi_ff || alt < hi_alt_ff) begin
            hi_alt_ff <= alt;
            ihi_ff    <= scan_idx_ff;
         end
      end
      if (cmd.latch_lo) begin
         lo_ff <= rd_entry;
      end
      if (cmd.latch_hi) begin
         den_ff   <= 16'(rd_entry.altitude - lo_ff.altitude);
         rem_ff   <= 16'(q_ff - lo_ff.altitude);
         diff_ff[wli_pkg::FLD_SPEED] <= 18'(rd_entry.speed) - 18'(lo_ff.speed);
         diff_ff[wli_pkg::FLD_DIR]   <= dir_adj;
         diff_ff[wli_pkg::FLD_VERT]  <= 18'(rd_entry.vertical) - 18'(lo_ff.vertical);
         diff_ff[wli_pkg::FLD_GUST]  <= 18'(rd_entry.gust) - 18'(lo_ff.gust);
         diff_ff[wli_pkg::FLD_TURB]  <= 18'(rd_entry.turbulence) - 18'(lo_ff.turbulence);
         rsp_ff.no_layers <= 1'b0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[15:0], quot_bit};
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_full[31:16];
      end
      if (add_vld_ff) begin
         case (add_field_ff)
            wli_pkg::FLD_SPEED: rsp_ff.wind_speed       <= sum;
            wli_pkg::FLD_DIR:   rsp_ff.wind_direction   <= sum;
            wli_pkg::FLD_VERT:  rsp_ff.vertical_wind    <= sum;
            wli_pkg::FLD_GUST:  rsp_ff.gust_speed       <= sum;
            default:            rsp_ff.turbulence_level <= sum;
         endcase
      end
      if (cmd.load_edge) begin
         rsp_ff.wind_speed       <= rd_entry.speed;
         rsp_ff.wind_direction   <= rd_entry.direction;
         rsp_ff.vertical_wind    <= rd_entry.vertical;
         rsp_ff.gust_speed       <= rd_entry.gust;
         rsp_ff.turbulence_level <= rd_entry.turbulence;
         rsp_ff.no_layers        <= 1'b0;
      end
      if (cmd.load_empty) begin
         rsp_ff.wind_speed       <= '0;
         rsp_ff.wind_direction   <= '0;
         rsp_ff.vertical_wind    <= '0;
         rsp_ff.gust_speed       <= '0;
         rsp_ff.turbulence_level <= '0;
         rsp_ff.no_layers        <= 1'b1;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wind_layer_interpolator_top.sv =====
// top level of the wind layer interpolator: register port, controller and datapath
//
// Usage: an item is taken on req_payload at a clock edge where req_start is high and
// req_busy is low. A write item (op = write) stores one layer at layer_index and gives
// no result; req_busy stays low. A query item returns one result on
// rsp_payload for exactly one cycle, marked by rsp_strobe; the receiver cannot stall it.
// The layer_count register (byte address 0 of the csr_ port) sets how many table
// entries a query looks at; write it only while no query is in flight.
// Flow, with n the number of layers looked at (layer_count, at most MAX_LAYERS):
//   no layers:              result in the cycle after the item, block never busy
//   at or beyond an edge:   scan of the n layers, then a read of the edge layer
//   between two layers:     scan of the n layers, reads of both layers, divide, blend
// A new item can be taken in the cycle that the result is shown. The time is set by the
// altitude scan, one table read a cycle through the single read port, then a 17-step
// serial divide for the blend fraction and one shared multiplier over five fields.
// Synchronous reset clears layer_count and the controller; the layer table is not
// cleared, so entries below layer_count must be written before they are queried.
`timescale 1ns / 1ps
`default_nettype none

module wind_layer_interpolator_top #(
   parameter int MAX_LAYERS = wli_pkg::MAX_LAYERS_DEFAULT,
   localparam int AW    = $clog2(MAX_LAYERS),
   localparam int CNT_W = $clog2(MAX_LAYERS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_start,
   output logic                   req_busy,
   input  wire wli_pkg::req_type  req_payload,
   output logic                   rsp_strobe,
   output wli_pkg::rsp_type       rsp_payload,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [1:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [wli_pkg::COUNT_W-1:0]   layer_count_ff, layer_count_in;
   logic [CNT_W-1:0]              layer_total;
   logic                          csr_write;
   wli_pkg::cmd_type              cmd;
   wli_pkg::status_type           status;
   logic [AW-1:0]                 scan_addr;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == wli_pkg::CSR_LAYER_COUNT_ADDR) ?
                       32'(layer_count_ff) : '0;

   assign layer_count_in = csr_write ? csr_pwdata[wli_pkg::COUNT_W-1:0] : layer_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_count_ff <= '0;
      end else begin
         layer_count_ff <= layer_count_in;
      end
   end

   // counts beyond the table size act as a full table
   assign layer_total = (32'(layer_count_ff) > 32'(MAX_LAYERS)) ?
                        CNT_W'(MAX_LAYERS) : CNT_W'(layer_count_ff);

   wli_ctrl #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_start),
      .op          (req_payload.op),
      .layer_total (layer_total),
      .status      (status),
      .busy        (req_busy),
      .cmd         (cmd),
      .scan_addr   (scan_addr)
   );

   wli_datapath #(
      .MAX_LAYERS (MAX_LAYERS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .scan_addr   (scan_addr),
      .req_payload (req_payload),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   a_empty_query_answers: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy && req_payload.op == wli_pkg::OP_QUERY && layer_total == '0)
      |=> (rsp_strobe && rsp_payload.no_layers))
      else $error("empty query did not answer in the next cycle");

   a_write_keeps_free: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy && req_payload.op == wli_pkg::OP_WRITE) |=> !req_busy)
      else $error("write item left the block busy");

   a_query_occupies: assert property (@(posedge clock) disable iff (reset)
      (req_start && !req_busy && req_payload.op == wli_pkg::OP_QUERY && layer_total != '0)
      |=> (req_busy && !rsp_strobe))
      else $error("query with layers did not start a scan");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.no_layers) |->
      (rsp_payload.wind_speed == '0 && rsp_payload.wind_direction == '0 &&
       rsp_payload.vertical_wind == '0 && rsp_payload.gust_speed == '0 &&
       rsp_payload.turbulence_level == '0))
      else $error("empty result carries non-zero fields");

endmodule

`default_nettype wire

// ===== test/wind_layer_interpolator_top_tb.sv =====
// self-checking testbench of the wind layer interpolator top level
`timescale 1ns / 1ps

module wind_layer_interpolator_top_tb;
   import wli_pkg::*;

   localparam int TABLE_DEPTH = 16;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_start;
   logic        req_busy;
   req_type     req_payload;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   req_type     pending_items[$];
   rsp_type     expected_wind[$];
   layer_type   layer_table[TABLE_DEPTH];
   logic [4:0]  layer_count_shadow;
   logic        item_taken;
   bit          steady;
   int          error_count;

   wind_layer_interpolator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_start   (req_start),
      .req_busy    (req_busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // blend two q8.8 / q0.16 values by a q0.16 fraction, product floored
   function automatic longint lerp_q16(longint lo, longint hi, longint frac);
      return lo + (((hi - lo) * frac) >>> 16);
   endfunction

   function automatic rsp_type layer_result(layer_type l);
      rsp_type r;
      r = '0;
      r.wind_speed       = l.speed;
      r.wind_direction   = l.direction;
      r.vertical_wind    = l.vertical;
      r.gust_speed       = l.gust;
      r.turbulence_level = l.turbulence;
      return r;
   endfunction

   function automatic rsp_type interpolate_wind(logic signed [15:0] query_alt);
      rsp_type   r;
      layer_type lo_l;
      layer_type hi_l;
      int        n, i, imin, imax, ilo, ihi, a, qi, alt_lo, alt_hi, dd;
      bit        have_lo, have_hi;
      longint    frac, d;
      r = '0;
      n = (layer_count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(layer_count_shadow);
      if (n == 0) begin
         r.no_layers = 1'b1;
         return r;
      end
      qi = $signed(query_alt);
      imin = 0;
      imax = 0;
      // strict compares keep the lowest index among equal altitudes
      for (i = 1; i < n; i++) begin
         a = $signed(layer_table[i].altitude);
         if (a < $signed(layer_table[imin].altitude)) imin = i;
         if (a > $signed(layer_table[imax].altitude)) imax = i;
      end
      if (qi <= $signed(layer_table[imin].altitude)) return layer_result(layer_table[imin]);
      if (qi >= $signed(layer_table[imax].altitude)) return layer_result(layer_table[imax]);
      ilo = 0;
      ihi = 0;
      have_lo = 1'b0;
      have_hi = 1'b0;
      for (i = 0; i < n; i++) begin
         a = $signed(layer_table[i].altitude);
         if (a < qi) begin
            if (!have_lo || a > $signed(layer_table[ilo].altitude)) begin
               ilo = i;
               have_lo = 1'b1;
            end
         end else begin
            if (!have_hi || a < $signed(layer_table[ihi].altitude)) begin
               ihi = i;
               have_hi = 1'b1;
            end
         end
      end
      lo_l = layer_table[ilo];
      hi_l = layer_table[ihi];
      alt_lo = $signed(lo_l.altitude);
      alt_hi = $signed(hi_l.altitude);
      frac = (longint'(qi - alt_lo) * 65536) / longint'(alt_hi - alt_lo);
      r.wind_speed = 16'(lerp_q16(lo_l.speed, hi_l.speed, frac));
      // shortest arc; an exact half turn keeps the sign of the raw difference
      dd = int'(hi_l.direction) - int'(lo_l.direction);
      if (dd > 32768) dd -= 65536;
      if (dd < -32768) dd += 65536;
      d = longint'(lo_l.direction) + ((longint'(dd) * frac) >>> 16);
      r.wind_direction = d[15:0];
      d = lerp_q16($signed(lo_l.vertical), $signed(hi_l.vertical), frac);
      r.vertical_wind = d[15:0];
      r.gust_speed = 16'(lerp_q16(lo_l.gust, hi_l.gust, frac));
      r.turbulence_level = 16'(lerp_q16(lo_l.turbulence, hi_l.turbulence, frac));
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // result check and prediction of each accepted item
   always @(posedge clock) begin
      if (reset) begin
         item_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (expected_wind.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
               error_count++;
            end else begin
               rsp_type want;
               want = expected_wind.pop_front();
               check_field("wind_speed", want.wind_speed, rsp_payload.wind_speed);
               check_field("wind_direction", want.wind_direction, rsp_payload.wind_direction);
               check_field("vertical_wind", want.vertical_wind, rsp_payload.vertical_wind);
               check_field("gust_speed", want.gust_speed, rsp_payload.gust_speed);
               check_field("turbulence_level", want.turbulence_level,
                           rsp_payload.turbulence_level);
               check_field("no_layers", want.no_layers, rsp_payload.no_layers);
            end
         end
         if (req_start && !req_busy) begin
            if (req_payload.op == OP_WRITE) begin
               layer_table[req_payload.layer_index] = '{
                  altitude:   req_payload.layer_altitude,
                  speed:      req_payload.layer_speed,
                  direction:  req_payload.layer_direction,
                  vertical:   req_payload.layer_vertical,
                  gust:       req_payload.layer_gust,
                  turbulence: req_payload.layer_turbulence};
            end else begin
               expected_wind.insert(expected_wind.size(),
                                    interpolate_wind(req_payload.query_altitude));
            end
         end
         item_taken <= req_start && !req_busy;
      end
   end

   // item driver: holds an item until it is taken, then idles now and then
   always @(negedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else if (!req_start || item_taken) begin
         if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
            req_payload <= pending_items.pop_front();
            req_start   <= 1'b1;
         end else begin
            req_start <= 1'b0;
         end
      end
   end

   function automatic int wild16();
      case ($urandom_range(9))
         0:       return 0;
         1:       return 65535;
         2:       return 32768;
         3:       return 32767;
         default: return $urandom_range(65535);
      endcase
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.op               = op_type'($urandom_range(1));
      r.layer_index      = 4'($urandom);
      r.layer_altitude   = 16'($urandom);
      r.layer_speed      = 16'($urandom);
      r.layer_direction  = 16'($urandom);
      r.layer_vertical   = 16'($urandom);
      r.layer_gust       = 16'($urandom);
      r.layer_turbulence = 16'($urandom);
      r.query_altitude   = 16'($urandom);
      return r;
   endfunction

   function automatic req_type layer_item(int idx, int alt, int spd, int dir, int vert,
                                          int gust, int turb);
      req_type r;
      r = random_item();
      r.op               = OP_WRITE;
      r.layer_index      = 4'(idx);
      r.layer_altitude   = 16'(alt);
      r.layer_speed      = 16'(spd);
      r.layer_direction  = 16'(dir);
      r.layer_vertical   = 16'(vert);
      r.layer_gust       = 16'(gust);
      r.layer_turbulence = 16'(turb);
      return r;
   endfunction

   function automatic req_type query_item(int alt);
      req_type r;
      r = random_item();
      r.op             = OP_QUERY;
      r.query_altitude = 16'(alt);
      return r;
   endfunction

   // append an item to the tail of the pending queue
   function automatic void queue_item(req_type r);
      pending_items.insert(pending_items.size(), r);
   endfunction

   task automatic set_layer_count(int value);
      @(negedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= CSR_LAYER_COUNT_ADDR;
      csr_pwdata <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      layer_count_shadow = 5'(value);
   endtask

   // wait for the table to go quiet before touching the register
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_start || expected_wind.size() != 0)
         @(posedge clock);
      repeat (48) @(posedge clock);
   endtask

   // layers drawn from a small altitude pool so ties and exact hits are common
   task automatic add_random_items(int count);
      int alt_pool[8];
      int span, base, dir_base, k, alt, dir;
      span = ($urandom_range(2) == 0) ? 64 : 65535;
      base = $urandom_range(65535 - span) - 32768;
      foreach (alt_pool[k]) alt_pool[k] = base + $urandom_range(span);
      if ($urandom_range(2) == 0) alt_pool[0] = -32768;
      if ($urandom_range(2) == 0) alt_pool[7] = 32767;
      dir_base = $urandom_range(65535);
      for (k = 0; k < count; k++) begin
         if ($urandom_range(99) < 28) begin
            alt = ($urandom_range(9) < 7) ? alt_pool[$urandom_range(7)]
                                          : $urandom_range(65535) - 32768;
            case ($urandom_range(3))
               0:       dir = dir_base;
               1:       dir = dir_base + 32768;
               default: dir = $urandom_range(65535);
            endcase
            queue_item(layer_item($urandom_range(15), alt, wild16(), dir,
                                  wild16(), wild16(), wild16()));
         end else begin
            case ($urandom_range(9))
               0, 1:    alt = alt_pool[$urandom_range(7)];
               2, 3:    alt = alt_pool[$urandom_range(7)] + $urandom_range(6) - 3;
               4:       alt = $urandom_range(1) ? 32767 : -32768;
               5:       alt = $urandom_range(65535) - 32768;
               default: alt = base + $urandom_range(span);
            endcase
            queue_item(query_item(alt));
         end
      end
   endtask

   initial begin
      int phase_counts[9];
      int p;
      reset       = 1'b1;
      req_start   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      layer_count_shadow = '0;
      steady      = 1'b0;
      error_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table first, then fill every entry before any count is set
      queue_item(query_item(-32768));
      queue_item(query_item(32767));
      queue_item(layer_item(0, -32768, 0, 16'h0000, -32768, 0, 0));
      queue_item(layer_item(1, -1000, 65535, 16'h4000, 32767, 65535, 65535));
      queue_item(layer_item(2, 0, 1000, 16'h1000, -256, 500, 1000));
      queue_item(layer_item(3, 100, 2000, 16'h9000, 256, 700, 3000));
      queue_item(layer_item(4, 200, 500, 16'h1000, -100, 100, 200));
      queue_item(layer_item(5, 300, 800, 16'hF000, 50, 900, 40000));
      queue_item(layer_item(6, 300, 9999, 16'h7777, 1234, 4321, 111));
      queue_item(layer_item(7, 1000, 300, 16'h0100, -32768, 65535, 0));
      queue_item(layer_item(8, 32767, 42, 16'hFFFF, 32767, 0, 65535));
      queue_item(layer_item(9, -32768, 7, 16'h1234, 77, 88, 99));
      queue_item(layer_item(10, 5000, wild16(), wild16(), wild16(), wild16(), wild16()));
      queue_item(layer_item(11, 8000, wild16(), wild16(), wild16(), wild16(), wild16()));
      queue_item(layer_item(12, 12000, wild16(), wild16(), wild16(), wild16(), wild16()));
      queue_item(layer_item(13, 20000, wild16(), wild16(), wild16(), wild16(), wild16()));
      queue_item(layer_item(14, 30000, wild16(), wild16(), wild16(), wild16(), wild16()));
      queue_item(layer_item(15, 32767, 1, 16'h8000, -1, 1, 1));
      wait_idle();
      set_layer_count(16);
      // edges, tiny fraction, exact layer hit, both half turns, tie and wrap
      queue_item(query_item(-32768));
      queue_item(query_item(-32767));
      queue_item(query_item(-2000));
      queue_item(query_item(0));
      queue_item(query_item(50));
      queue_item(query_item(150));
      queue_item(query_item(250));
      queue_item(query_item(650));
      queue_item(query_item(32767));
      wait_idle();

      phase_counts = '{16, 1, 2, 31, 0, 9, 17, 16, $urandom_range(31)};
      for (p = 0; p < 9; p++) begin
         steady = (p == 3);
         set_layer_count(phase_counts[p]);
         add_random_items(215);
         wait_idle();
      end

      if (error_count == 0 && expected_wind.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
